### rtl/dvre_pkg.sv
// Shared types, constants and codes of the distance-vector route engine.
package dvre_pkg;

  localparam int MAX_PORTS_DEF   = 16;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int PORT_SLOTS      = 16;

  localparam logic [31:0] PING_PERIOD   = 32'd10000;
  localparam logic [31:0] NBR_TIMEOUT   = 32'd15000;
  localparam logic [31:0] ROUTE_TIMEOUT = 32'd45000;
  localparam logic [31:0] ADVERT_PERIOD = 32'd30000;
  localparam logic [29:0] COST_INF      = 30'd1000000000;
  localparam logic [15:0] COST_UNREACH  = 16'hFFFF;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_PONG   = 3'd1;
  localparam logic [2:0] ACT_DV     = 3'd2;
  localparam logic [2:0] ACT_LOOKUP = 3'd3;
  localparam logic [2:0] ACT_ADVERT = 3'd4;

  localparam logic [1:0] REG_OWN_ID     = 2'd0;
  localparam logic [1:0] REG_PORT_COUNT = 2'd1;
  localparam logic [1:0] REG_DV_MODE    = 2'd2;

  typedef enum logic [2:0] {
    PH_CLR,
    PH_IDLE,
    PH_EXEC,
    PH_EVAL,
    PH_SWEEP,
    PH_OWNRD,
    PH_OWNCHK
  } phase_t;

  typedef struct packed {
    phase_t phase;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic dv_on;
    logic sweep_done;
    logic clr_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/distance_vector_route_engine_core.sv
// Top level of the distance-vector route engine: sequencer plus datapath.
// Each item is latched, then passes the exec, eval, own-id read and own-id check phases
// before its result is registered; a tick skips eval, and in dv mode it sweeps the route
// table memory one entry per cycle between exec and the own-id read.
// One item at a time: the next input transfer is taken once a result sits in the output
// register. Reset: synchronous; after it the route valid memory is cleared entry by entry,
// and no input transfer is taken until that pass is done.
module distance_vector_route_engine_core #(
  parameter int MAX_PORTS   = dvre_pkg::MAX_PORTS_DEF,
  parameter int TABLE_DEPTH = dvre_pkg::TABLE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // input items
  input  logic         s_tvalid,
  output logic         s_tready,
  // port[3:0], now_ms[35:4], peer_id[51:36], ping_stamp[83:52],
  // dest_id[99:84], adv_cost[115:100], zero fill[119:116]
  input  logic [119:0] s_tdata,
  // action[2:0]
  input  logic [2:0]   s_tuser,
  // last_entry
  input  logic         s_tlast,
  // results
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_port[3:0], forward_ok[4], deliver_local[5], table_changed[6],
  // advert_skip[7], send_pings[8], periodic_advert[9], entry_valid[10],
  // entry_cost[26:11], route_count[37:27], neighbor_id[53:38],
  // port_alive[54], zero fill[55]
  output logic [55:0]  m_tdata,
  // configuration writes: 0 own_id, 1 port_count, 2 dv_mode
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  dvre_pkg::cmd_t cmd;
  dvre_pkg::sts_t sts;

  // sequencer: one phase per cycle; sweep waits on sweep_done, own-id check on out_free
  dvre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: neighbor records, route table memories, result register
  dvre_dp #(
    .MAX_PORTS   (MAX_PORTS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

endmodule

### rtl/dvre_ctrl.sv
// Sequencer of the route engine: walks each item through its phases.
module dvre_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  dvre_pkg::sts_t sts,
  output dvre_pkg::cmd_t cmd
);

  dvre_pkg::phase_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dvre_pkg::PH_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      dvre_pkg::PH_CLR: begin
        if (sts.clr_done) state_next = dvre_pkg::PH_IDLE;
      end
      dvre_pkg::PH_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = dvre_pkg::PH_EXEC;
      end
      dvre_pkg::PH_EXEC: begin
        if (!sts.is_tick) state_next = dvre_pkg::PH_EVAL;
        else if (sts.dv_on) state_next = dvre_pkg::PH_SWEEP;
        else state_next = dvre_pkg::PH_OWNRD;
      end
      dvre_pkg::PH_EVAL:  state_next = dvre_pkg::PH_OWNRD;
      dvre_pkg::PH_SWEEP: begin
        if (sts.sweep_done) state_next = dvre_pkg::PH_OWNRD;
      end
      dvre_pkg::PH_OWNRD: state_next = dvre_pkg::PH_OWNCHK;
      dvre_pkg::PH_OWNCHK: begin
        if (sts.out_free) state_next = dvre_pkg::PH_IDLE;
      end
      default: state_next = dvre_pkg::PH_CLR;
    endcase
    cmd.phase = state;
  end

endmodule

### rtl/dvre_dp.sv
// Datapath of the route engine: neighbor records, route table and result register.
module dvre_dp #(
  parameter int MAX_PORTS   = dvre_pkg::MAX_PORTS_DEF,
  parameter int TABLE_DEPTH = dvre_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  dvre_pkg::cmd_t cmd,
  output dvre_pkg::sts_t sts,
  input  logic           s_tvalid,
  input  logic [119:0]   s_tdata,
  input  logic [2:0]     s_tuser,
  input  logic           s_tlast,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [55:0]    m_tdata,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_addr,
  input  logic [15:0]    cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int NS = dvre_pkg::PORT_SLOTS;

  // configuration
  logic [15:0] own_id;
  logic [4:0]  port_count;
  logic        dv_mode;

  // latched item
  logic [2:0]  act;
  logic [3:0]  prt;
  logic [31:0] now;
  logic [15:0] peer;
  logic [31:0] stamp;
  logic [15:0] dest;
  logic [15:0] adv;
  logic        last;

  // neighbor records
  logic [NS-1:0] nbr_alive;
  logic [15:0]   nbr_router    [NS];
  logic [31:0]   nbr_last_pong [NS];
  logic [31:0]   nbr_rtt       [NS];

  logic [15:0]   highest_seen;
  logic [31:0]   last_ping_time;
  logic [31:0]   last_periodic_time;
  logic          pkt_changed;
  logic [CW-1:0] valid_count;

  // route table
  logic          vmem [TABLE_DEPTH];
  logic [3:0]    emem [TABLE_DEPTH];
  logic [29:0]   cmem [TABLE_DEPTH];
  logic [31:0]   tmem [TABLE_DEPTH];
  logic          rd_v;
  logic [3:0]    rd_e;
  logic [29:0]   rd_c;
  logic [31:0]   rd_t;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] w_addr;
  logic          v_we, v_wd, e_we, c_we, t_we;
  logic [3:0]    e_wd;
  logic [29:0]   c_wd;

  // work registers
  logic [CW-1:0] idx;
  logic          sw_pv;
  logic [AW-1:0] sw_addr;
  logic [NS-1:0] dead;
  logic [31:0]   rtt;
  logic [29:0]   price;
  logic          lk_tbl;

  // result being built
  logic [3:0]  r_port;
  logic        r_fwd, r_local, r_chg, r_ping, r_per, r_ev, r_alive;
  logic [15:0] r_cost, r_nid;

  logic          out_valid;
  logic [55:0]   out_data;

  // decoded conditions
  logic [6:0]    np;
  logic          prt_ok, peer_in, dest_in, own_in;
  logic          pong_tbl, dv_ok, dv_tbl;
  logic [AW-1:0] tgt;
  logic          accept;
  logic          out_free;
  logic          sw_drop;
  logic [31:0]   sw_age;
  logic [29:0]   pong_cost;
  logic          pong_upd;
  logic          dv_via, dv_upd, dv_inf;
  logic [32:0]   dv_sum;
  logic [NS-1:0] dead_now;
  logic          nb_found;
  logic [3:0]    nb_port;
  logic [CW-1:0] cnt;
  logic          o_chg, o_skip;
  logic [31:0]   rtt_now;

  assign np = ({2'b0, port_count} < 7'(MAX_PORTS)) ? {2'b0, port_count} : 7'(MAX_PORTS);
  assign prt_ok   = ({3'b0, prt} < np);
  assign peer_in  = ({1'b0, peer} < 17'(TABLE_DEPTH));
  assign dest_in  = ({1'b0, dest} < 17'(TABLE_DEPTH));
  assign own_in   = ({1'b0, own_id} < 17'(TABLE_DEPTH));
  assign pong_tbl = prt_ok && peer_in && (peer != own_id);
  assign dv_ok    = dv_mode && prt_ok && nbr_alive[prt];
  assign dv_tbl   = dv_ok && dest_in && (dest != own_id);
  assign tgt      = (act == dvre_pkg::ACT_PONG) ? AW'(peer) : AW'(dest);
  assign accept   = (cmd.phase == dvre_pkg::PH_IDLE) && s_tvalid;
  assign out_free = !out_valid || m_tready;
  assign rtt_now  = (now >= stamp) ? now - stamp : 32'd0;

  assign sts.is_tick    = (act == dvre_pkg::ACT_TICK);
  assign sts.dv_on      = dv_mode;
  assign sts.sweep_done = (idx == CW'(TABLE_DEPTH)) && !sw_pv;
  assign sts.clr_done   = (idx == CW'(TABLE_DEPTH - 1));
  assign sts.out_free   = out_free;

  // neighbor search and dead-port mask
  always_comb begin
    nb_found = 1'b0;
    nb_port  = 4'd0;
    for (int p = NS - 1; p >= 0; p--) begin
      dead_now[p] = (7'(p) < np) && nbr_alive[p] &&
                    ((now - nbr_last_pong[p]) >= dvre_pkg::NBR_TIMEOUT);
      if ((7'(p) < np) && nbr_alive[p] && (nbr_router[p] == dest)) begin
        nb_found = 1'b1;
        nb_port  = 4'(p);
      end
    end
  end

  // per-entry decisions
  always_comb begin
    sw_age    = now - rd_t;
    sw_drop   = sw_pv && rd_v &&
                (dead[rd_e] || ((16'(sw_addr) != own_id) && (sw_age >= dvre_pkg::ROUTE_TIMEOUT)));
    pong_cost = (rtt < {2'b0, dvre_pkg::COST_INF}) ? rtt[29:0] : dvre_pkg::COST_INF;
    pong_upd  = dv_mode && (!rd_v || (rd_e != prt) || (rd_c != pong_cost));
    dv_sum    = {17'b0, adv} + {1'b0, nbr_rtt[prt]};
    dv_inf    = (price == dvre_pkg::COST_INF);
    dv_via    = rd_v && (rd_e == prt);
    dv_upd    = !rd_v || (price < rd_c) || (dv_via && (price != rd_c));
  end

  // table port control
  always_comb begin
    rd_addr = tgt;
    w_addr  = tgt;
    v_we = 1'b0; v_wd = 1'b0; e_we = 1'b0; c_we = 1'b0; t_we = 1'b0;
    e_wd = prt;
    c_wd = price;
    case (cmd.phase)
      dvre_pkg::PH_CLR: begin
        w_addr = idx[AW-1:0];
        v_we   = 1'b1;
      end
      dvre_pkg::PH_SWEEP: begin
        rd_addr = idx[AW-1:0];
        w_addr  = sw_addr;
        v_we    = sw_drop;
      end
      // keep the own-id entry on the read port while the result waits
      dvre_pkg::PH_OWNRD, dvre_pkg::PH_OWNCHK: rd_addr = AW'(own_id);
      dvre_pkg::PH_EVAL: begin
        if (act == dvre_pkg::ACT_PONG && pong_tbl) begin
          t_we = 1'b1;
          c_wd = pong_cost;
          if (pong_upd) begin
            v_we = 1'b1; v_wd = 1'b1; e_we = 1'b1; c_we = 1'b1;
          end
        end else if (act == dvre_pkg::ACT_DV && dv_tbl) begin
          if (dv_inf) begin
            v_we = dv_via;
          end else begin
            t_we = dv_via || dv_upd;
            if (dv_upd) begin
              v_we = 1'b1; v_wd = 1'b1; e_we = 1'b1; c_we = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_we) vmem[w_addr] <= v_wd;
    rd_v <= vmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[w_addr] <= e_wd;
    rd_e <= emem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) cmem[w_addr] <= c_wd;
    rd_c <= cmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (t_we) tmem[w_addr] <= now;
    rd_t <= tmem[rd_addr];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      own_id     <= 16'd0;
      port_count <= 5'd1;
      dv_mode    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        dvre_pkg::REG_OWN_ID:     own_id     <= cfg_wdata;
        dvre_pkg::REG_PORT_COUNT: port_count <= cfg_wdata[4:0];
        dvre_pkg::REG_DV_MODE:    dv_mode    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // item latch (payload)
  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= s_tuser;
      prt   <= s_tdata[3:0];
      now   <= s_tdata[35:4];
      peer  <= s_tdata[51:36];
      stamp <= s_tdata[83:52];
      dest  <= s_tdata[99:84];
      adv   <= s_tdata[115:100];
      last  <= s_tlast;
    end
  end

  always_comb begin
    cnt    = valid_count;
    if (own_in && rd_v) cnt = valid_count - CW'(1);
    o_chg  = r_chg;
    o_skip = 1'b0;
    if (act == dvre_pkg::ACT_DV) begin
      o_chg  = last && pkt_changed;
      o_skip = last && pkt_changed;
    end
  end

  // control state and phase work
  always_ff @(posedge clk) begin
    if (rst) begin
      nbr_alive          <= '0;
      highest_seen       <= 16'd0;
      last_ping_time     <= 32'd0;
      last_periodic_time <= 32'd0;
      pkt_changed        <= 1'b0;
      valid_count        <= '0;
      idx                <= '0;
      sw_pv              <= 1'b0;
      for (int p = 0; p < NS; p++) begin
        nbr_router[p]    <= 16'd0;
        nbr_last_pong[p] <= 32'd0;
        nbr_rtt[p]       <= 32'd0;
      end
    end else begin
      case (cmd.phase)
        dvre_pkg::PH_CLR: idx <= idx + CW'(1);
        dvre_pkg::PH_IDLE: begin
          if (accept) begin
            {r_port, r_fwd, r_local, r_chg, r_ping, r_per, r_ev, r_alive} <= '0;
            r_cost <= 16'd0;
            r_nid  <= 16'd0;
          end
        end
        dvre_pkg::PH_EXEC: begin
          idx    <= '0;
          sw_pv  <= 1'b0;
          rtt    <= rtt_now;
          lk_tbl <= 1'b0;
          price  <= (adv == dvre_pkg::COST_UNREACH || dv_sum >= {3'b0, dvre_pkg::COST_INF}) ?
                    dvre_pkg::COST_INF : dv_sum[29:0];
          case (act)
            dvre_pkg::ACT_TICK: begin
              if ((now - last_ping_time) >= dvre_pkg::PING_PERIOD) begin
                r_ping         <= 1'b1;
                last_ping_time <= now;
              end
              dead      <= dead_now;
              nbr_alive <= nbr_alive & ~dead_now;
              if (dv_mode && (now - last_periodic_time) >= dvre_pkg::ADVERT_PERIOD) begin
                r_per              <= 1'b1;
                last_periodic_time <= now;
              end
            end
            dvre_pkg::ACT_PONG: begin
              if (prt_ok) begin
                if (peer > highest_seen) highest_seen <= peer;
                nbr_alive[prt]     <= 1'b1;
                nbr_router[prt]    <= peer;
                nbr_last_pong[prt] <= now;
                nbr_rtt[prt]       <= rtt_now;
              end
            end
            dvre_pkg::ACT_DV: begin
              if (dv_ok && dest > highest_seen) highest_seen <= dest;
            end
            dvre_pkg::ACT_LOOKUP: begin
              if (dest == own_id) begin
                r_local <= 1'b1;
              end else if (nb_found) begin
                r_port <= nb_port;
                r_fwd  <= 1'b1;
              end else begin
                lk_tbl <= dv_mode && dest_in;
              end
            end
            dvre_pkg::ACT_ADVERT: begin
              if (prt_ok) begin
                r_nid   <= nbr_router[prt];
                r_alive <= nbr_alive[prt];
              end
            end
            default: ;
          endcase
        end
        dvre_pkg::PH_EVAL: begin
          case (act)
            dvre_pkg::ACT_PONG: begin
              if (pong_tbl && pong_upd) begin
                r_chg <= 1'b1;
                if (!rd_v) valid_count <= valid_count + CW'(1);
              end
            end
            dvre_pkg::ACT_DV: begin
              if (dv_tbl) begin
                if (dv_inf) begin
                  if (dv_via) begin
                    valid_count <= valid_count - CW'(1);
                    pkt_changed <= 1'b1;
                  end
                end else if (dv_upd) begin
                  pkt_changed <= 1'b1;
                  if (!rd_v) valid_count <= valid_count + CW'(1);
                end
              end
            end
            dvre_pkg::ACT_LOOKUP: begin
              if (lk_tbl && rd_v && ({3'b0, rd_e} < np) && nbr_alive[rd_e]) begin
                r_port <= rd_e;
                r_fwd  <= 1'b1;
              end
            end
            dvre_pkg::ACT_ADVERT: begin
              if (dv_mode && dest_in && (dest != own_id) && rd_v) begin
                r_ev <= 1'b1;
                if (prt_ok && rd_e == prt) r_cost <= dvre_pkg::COST_UNREACH;
                else if (rd_c < 30'(dvre_pkg::COST_UNREACH)) r_cost <= rd_c[15:0];
                else r_cost <= dvre_pkg::COST_UNREACH;
              end
            end
            default: ;
          endcase
        end
        dvre_pkg::PH_SWEEP: begin
          // evaluate the entry read last cycle, issue the next read
          if (sw_drop) begin
            valid_count <= valid_count - CW'(1);
            r_chg       <= 1'b1;
          end
          if (idx != CW'(TABLE_DEPTH)) begin
            sw_pv   <= 1'b1;
            sw_addr <= idx[AW-1:0];
            idx     <= idx + CW'(1);
          end else begin
            sw_pv <= 1'b0;
          end
        end
        dvre_pkg::PH_OWNCHK: begin
          if (out_free && act == dvre_pkg::ACT_DV && last) pkt_changed <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.phase == dvre_pkg::PH_OWNCHK && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.phase == dvre_pkg::PH_OWNCHK && out_free) begin
      out_data <= {1'b0, r_alive, r_nid, 11'(cnt), r_cost, r_ev, r_per, r_ping,
                   o_skip, o_chg, r_local, r_fwd, r_port};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule
